### src/manchester_frame_receiver_top_macros.svh
// Assertion macros for the Manchester frame receiver.
`ifndef MANCHESTER_FRAME_RECEIVER_TOP_MACROS_SVH
`define MANCHESTER_FRAME_RECEIVER_TOP_MACROS_SVH

// Generic clocked assertion, disabled while reset is high.
`define MFR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion on the block clock and reset.
`define MFR_CHECK(lbl, prop, msg) \
   `MFR_ASSERT(lbl, clock, reset, prop, msg)

`endif

### src/mfr_pkg.sv
`timescale 1ns / 1ps

package mfr_pkg;

   localparam int unsigned TIME_W  = 16;
   localparam int unsigned PHASE_W = 7;
   localparam int unsigned FRAME_W = 32;
   localparam int unsigned IDLE_W  = 8;

   localparam logic [1:0] KIND_EDGE    = 2'd0;
   localparam logic [1:0] KIND_TICK    = 2'd1;
   localparam logic [1:0] KIND_RELEASE = 2'd2;

   localparam logic [2:0] CSR_HALF_BIT_MIN = 3'd0;
   localparam logic [2:0] CSR_HALF_BIT_MAX = 3'd1;
   localparam logic [2:0] CSR_FULL_BIT_MIN = 3'd2;
   localparam logic [2:0] CSR_FULL_BIT_MAX = 3'd3;
   localparam logic [2:0] CSR_IDLE_TIMEOUT = 3'd4;

   localparam logic [PHASE_W-1:0] PHASE_IDLE    = 7'd0;
   localparam logic [PHASE_W-1:0] PHASE_START   = 7'd1;
   localparam logic [PHASE_W-1:0] PHASE_FIRST   = 7'd2;
   localparam logic [PHASE_W-1:0] PHASE_RX_LAST = 7'd66;
   localparam logic [PHASE_W-1:0] PHASE_DONE    = 7'd68;
   localparam logic [IDLE_W-1:0]  IDLE_SAT      = 8'hFF;

   typedef struct packed {
      logic [TIME_W-1:0] half_bit_min;
      logic [TIME_W-1:0] half_bit_max;
      logic [TIME_W-1:0] full_bit_min;
      logic [TIME_W-1:0] full_bit_max;
      logic [IDLE_W-1:0] idle_timeout;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0]  last_edge_time;
      logic [TIME_W-1:0]  last_interval;
      logic [PHASE_W-1:0] phase;
      logic [FRAME_W-1:0] frame;
      logic [IDLE_W-1:0]  idle_ticks;
   } state_type;

endpackage

### src/mfr_step.sv
`timescale 1ns / 1ps

module mfr_step (
   input  mfr_pkg::cfg_type              cfg,
   input  mfr_pkg::state_type            state_ff,
   input  logic [1:0]                    kind,
   input  logic [mfr_pkg::TIME_W-1:0]    edge_time,
   output mfr_pkg::state_type            state_in
);

   logic [mfr_pkg::TIME_W-1:0]  gap;
   logic [mfr_pkg::TIME_W-1:0]  period;
   logic [mfr_pkg::IDLE_W-1:0]  idle_inc;
   logic                        half_ok;
   logic                        full_ok;
   logic                        period_ok;

   assign gap       = edge_time - state_ff.last_edge_time;
   assign period    = state_ff.last_interval + gap;
   assign half_ok   = (gap >= cfg.half_bit_min) && (gap <= cfg.half_bit_max);
   assign full_ok   = (gap >= cfg.full_bit_min) && (gap <= cfg.full_bit_max);
   assign period_ok = (period >= cfg.full_bit_min) && (period <= cfg.full_bit_max);
   assign idle_inc  = (state_ff.idle_ticks == mfr_pkg::IDLE_SAT) ?
                      state_ff.idle_ticks : state_ff.idle_ticks + 8'd1;

   always_comb begin
      state_in = state_ff;
      case (kind)
         mfr_pkg::KIND_EDGE: begin
            state_in.last_edge_time = edge_time;
            state_in.last_interval  = gap;
            state_in.idle_ticks     = '0;
            if (state_ff.phase == mfr_pkg::PHASE_IDLE) begin
               state_in.phase = mfr_pkg::PHASE_START;
            end else if (state_ff.phase >= mfr_pkg::PHASE_DONE) begin
               state_in.phase = state_ff.phase;
            end else if (half_ok) begin
               if (state_ff.phase == mfr_pkg::PHASE_START) begin
                  state_in.phase = mfr_pkg::PHASE_FIRST;
                  state_in.frame = 32'd1;
               end else if (state_ff.phase[0]) begin
                  if (period_ok) begin
                     state_in.phase = state_ff.phase + 7'd1;
                     if (state_in.phase < mfr_pkg::PHASE_DONE) begin
                        state_in.frame = {state_ff.frame[30:0], state_ff.frame[0]};
                     end
                  end else begin
                     state_in.phase = mfr_pkg::PHASE_IDLE;
                  end
               end else begin
                  state_in.phase = state_ff.phase + 7'd1;
               end
            end else if (full_ok) begin
               if (state_ff.phase[0]) begin
                  state_in.phase = mfr_pkg::PHASE_IDLE;
               end else begin
                  state_in.phase = state_ff.phase + 7'd2;
                  if (state_in.phase < mfr_pkg::PHASE_DONE) begin
                     state_in.frame = {state_ff.frame[30:0], ~state_ff.frame[0]};
                  end
               end
            end else begin
               state_in.phase = mfr_pkg::PHASE_IDLE;
            end
         end
         mfr_pkg::KIND_TICK: begin
            state_in.idle_ticks = idle_inc;
            if ((idle_inc > cfg.idle_timeout) && (state_ff.phase < mfr_pkg::PHASE_DONE)) begin
               state_in.phase = mfr_pkg::PHASE_IDLE;
            end
         end
         mfr_pkg::KIND_RELEASE: begin
            state_in.phase = mfr_pkg::PHASE_IDLE;
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

endmodule

### src/manchester_frame_receiver_top.sv
// The result of an accepted word is registered onto the rsp_ outputs.
// Throughput: one word per cycle while rsp_ drains; one compare/shift pass.
// req_ready stays high while the result register is empty or being drained.
// Reset (synchronous, active high) clears decode state, drops rsp_valid and
// restores the timing windows to 250/750/750/1250 us and the timeout to 20.
`timescale 1ns / 1ps

module manchester_frame_receiver_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_kind,
   input  logic [mfr_pkg::TIME_W-1:0]    req_edge_time,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mfr_pkg::PHASE_W-1:0]   rsp_phase,
   output logic                          rsp_frame_ready,
   output logic                          rsp_receiving,
   output logic [mfr_pkg::FRAME_W-1:0]   rsp_frame_word,
   output logic                          rsp_parity_good,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [2:0]                    csr_index,
   input  logic [15:0]                   csr_data
);

   mfr_pkg::cfg_type              cfg_ff;
   mfr_pkg::state_type            state_ff;
   mfr_pkg::state_type            state_in;
   logic                          rsp_valid_ff;
   logic [mfr_pkg::PHASE_W-1:0]   rsp_phase_ff;
   logic                          rsp_frame_ready_ff;
   logic                          rsp_receiving_ff;
   logic [mfr_pkg::FRAME_W-1:0]   rsp_frame_word_ff;
   logic                          rsp_parity_good_ff;
   logic                          req_take;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   mfr_step u_step (
      .cfg       (cfg_ff),
      .state_ff  (state_ff),
      .kind      (req_kind),
      .edge_time (req_edge_time),
      .state_in  (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_bit_min <= 16'd250;
         cfg_ff.half_bit_max <= 16'd750;
         cfg_ff.full_bit_min <= 16'd750;
         cfg_ff.full_bit_max <= 16'd1250;
         cfg_ff.idle_timeout <= 8'd20;
      end else if (csr_valid) begin
         case (csr_index)
            mfr_pkg::CSR_HALF_BIT_MIN: cfg_ff.half_bit_min <= csr_data;
            mfr_pkg::CSR_HALF_BIT_MAX: cfg_ff.half_bit_max <= csr_data;
            mfr_pkg::CSR_FULL_BIT_MIN: cfg_ff.full_bit_min <= csr_data;
            mfr_pkg::CSR_FULL_BIT_MAX: cfg_ff.full_bit_max <= csr_data;
            mfr_pkg::CSR_IDLE_TIMEOUT: cfg_ff.idle_timeout <= csr_data[7:0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_phase_ff       <= state_in.phase;
         rsp_frame_ready_ff <= (state_in.phase >= mfr_pkg::PHASE_DONE);
         rsp_receiving_ff   <= (state_in.phase != mfr_pkg::PHASE_IDLE) &&
                               (state_in.phase <= mfr_pkg::PHASE_RX_LAST);
         rsp_frame_word_ff  <= state_in.frame;
         rsp_parity_good_ff <= ~(^state_in.frame);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_phase       = rsp_phase_ff;
   assign rsp_frame_ready = rsp_frame_ready_ff;
   assign rsp_receiving   = rsp_receiving_ff;
   assign rsp_frame_word  = rsp_frame_word_ff;
   assign rsp_parity_good = rsp_parity_good_ff;

endmodule

### src/mfr_checker.sv
`timescale 1ns / 1ps
`include "manchester_frame_receiver_top_macros.svh"

module mfr_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [1:0]                    req_kind,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [mfr_pkg::PHASE_W-1:0]   rsp_phase,
   input  logic                          rsp_frame_ready,
   input  logic [mfr_pkg::FRAME_W-1:0]   rsp_frame_word,
   input  logic                          rsp_parity_good
);

   logic rsp_stall;
   logic req_take;
   logic req_release;
   logic phase_done;
   logic parity_even;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign req_take    = req_valid && req_ready;
   assign req_release = req_take && (req_kind == mfr_pkg::KIND_RELEASE);
   assign phase_done  = (rsp_phase == mfr_pkg::PHASE_DONE);
   assign parity_even = ~(^rsp_frame_word);

   `MFR_CHECK(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_frame_word), "rsp word not held")
   `MFR_CHECK(a_accept_rsp, req_take |=> rsp_valid, "accepted word produced no rsp")
   `MFR_CHECK(a_release_idle, req_release |=> rsp_phase == mfr_pkg::PHASE_IDLE, "phase not idle")
   `MFR_CHECK(a_ready_phase, rsp_valid |-> rsp_frame_ready == phase_done, "frame_ready wrong")
   `MFR_CHECK(a_parity, rsp_valid |-> rsp_parity_good == parity_even, "parity flag wrong")

endmodule

bind manchester_frame_receiver_top mfr_checker u_mfr_checker (.*);

### verif/tb_manchester_frame_receiver_top.sv
`timescale 1ns / 1ps

module tb_manchester_frame_receiver_top;

   localparam logic [1:0] KIND_UNUSED  = 2'd3;
   localparam logic [2:0] CSR_UNMAPPED = 3'd7;

   typedef struct packed {
      logic [mfr_pkg::PHASE_W-1:0] phase;
      logic                        frame_ready;
      logic                        receiving;
      logic [mfr_pkg::FRAME_W-1:0] frame_word;
      logic                        parity_good;
   } rx_status_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [1:0]                   req_kind = mfr_pkg::KIND_EDGE;
   logic [mfr_pkg::TIME_W-1:0]   req_edge_time = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [mfr_pkg::PHASE_W-1:0]  rsp_phase;
   logic                         rsp_frame_ready;
   logic                         rsp_receiving;
   logic [mfr_pkg::FRAME_W-1:0]  rsp_frame_word;
   logic                         rsp_parity_good;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [2:0]                   csr_index = mfr_pkg::CSR_HALF_BIT_MIN;
   logic [15:0]                  csr_data = '0;

   mfr_pkg::cfg_type             win_cfg;
   mfr_pkg::state_type           decoder;
   rx_status_type                status_due[$];
   int                           fail_count = 0;
   logic [mfr_pkg::TIME_W-1:0]   line_time = '0;
   int                           src_idle_pct = 0;
   int                           sink_idle_pct = 0;
   int                           stall_request = 0;
   int                           stall_left = 0;

   manchester_frame_receiver_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_edge_time   (req_edge_time),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_phase       (rsp_phase),
      .rsp_frame_ready (rsp_frame_ready),
      .rsp_receiving   (rsp_receiving),
      .rsp_frame_word  (rsp_frame_word),
      .rsp_parity_good (rsp_parity_good),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic in_span(input logic [mfr_pkg::TIME_W-1:0] v,
                                    input logic [mfr_pkg::TIME_W-1:0] lo,
                                    input logic [mfr_pkg::TIME_W-1:0] hi);
      return v >= lo && v <= hi;
   endfunction

   function automatic void decode_event(input logic [1:0] kind,
                                        input logic [mfr_pkg::TIME_W-1:0] t);
      logic [mfr_pkg::TIME_W-1:0] gap;
      logic [mfr_pkg::TIME_W-1:0] period;
      rx_status_type              status;
      case (kind)
         mfr_pkg::KIND_EDGE: begin
            gap = t - decoder.last_edge_time;
            decoder.last_edge_time = t;
            if (decoder.phase == mfr_pkg::PHASE_IDLE) begin
               decoder.phase = mfr_pkg::PHASE_START;
            end else if (decoder.phase >= mfr_pkg::PHASE_DONE) begin
            end else if (in_span(gap, win_cfg.half_bit_min, win_cfg.half_bit_max)) begin
               if (decoder.phase == mfr_pkg::PHASE_START) begin
                  decoder.phase = mfr_pkg::PHASE_FIRST;
                  decoder.frame = 32'd1;
               end else if (decoder.phase[0]) begin
                  period = decoder.last_interval + gap;
                  if (in_span(period, win_cfg.full_bit_min, win_cfg.full_bit_max)) begin
                     decoder.phase = decoder.phase + 7'd1;
                     if (decoder.phase < mfr_pkg::PHASE_DONE)
                        decoder.frame = {decoder.frame[mfr_pkg::FRAME_W-2:0],
                                         decoder.frame[0]};
                  end else begin
                     decoder.phase = mfr_pkg::PHASE_IDLE;
                  end
               end else begin
                  decoder.phase = decoder.phase + 7'd1;
               end
            end else if (in_span(gap, win_cfg.full_bit_min, win_cfg.full_bit_max)) begin
               if (decoder.phase[0]) begin
                  decoder.phase = mfr_pkg::PHASE_IDLE;
               end else begin
                  decoder.phase = decoder.phase + 7'd2;
                  if (decoder.phase < mfr_pkg::PHASE_DONE)
                     decoder.frame = {decoder.frame[mfr_pkg::FRAME_W-2:0],
                                      ~decoder.frame[0]};
               end
            end else begin
               decoder.phase = mfr_pkg::PHASE_IDLE;
            end
            decoder.last_interval = gap;
            decoder.idle_ticks = '0;
         end
         mfr_pkg::KIND_TICK: begin
            if (decoder.idle_ticks != mfr_pkg::IDLE_SAT)
               decoder.idle_ticks = decoder.idle_ticks + 8'd1;
            if (decoder.idle_ticks > win_cfg.idle_timeout &&
                decoder.phase < mfr_pkg::PHASE_DONE)
               decoder.phase = mfr_pkg::PHASE_IDLE;
         end
         mfr_pkg::KIND_RELEASE: begin
            decoder.phase = mfr_pkg::PHASE_IDLE;
         end
         default: begin
         end
      endcase
      status.phase       = decoder.phase;
      status.frame_ready = decoder.phase >= mfr_pkg::PHASE_DONE;
      status.receiving   = decoder.phase >= mfr_pkg::PHASE_START &&
                           decoder.phase <= mfr_pkg::PHASE_RX_LAST;
      status.frame_word  = decoder.frame;
      status.parity_good = ~^decoder.frame;
      status_due.push_back(status);
   endfunction

   always @(posedge clock) begin
      if (stall_request != 0) begin
         stall_left = stall_request;
         stall_request = 0;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   always @(posedge clock) begin : check_status
      rx_status_type want;
      rx_status_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = {rsp_phase, rsp_frame_ready, rsp_receiving, rsp_frame_word, rsp_parity_good};
         if (status_due.size() == 0) begin
            $error("status word with nothing pending: phase %0d frame %h",
                   seen.phase, seen.frame_word);
            fail_count++;
         end else begin
            want = status_due.pop_front();
            if (seen.phase !== want.phase) begin
               $error("phase: expected %0d, got %0d", want.phase, seen.phase);
               fail_count++;
            end
            if (seen.frame_ready !== want.frame_ready) begin
               $error("frame_ready: expected %0b, got %0b", want.frame_ready, seen.frame_ready);
               fail_count++;
            end
            if (seen.receiving !== want.receiving) begin
               $error("receiving: expected %0b, got %0b", want.receiving, seen.receiving);
               fail_count++;
            end
            if (seen.frame_word !== want.frame_word) begin
               $error("frame_word: expected %h, got %h", want.frame_word, seen.frame_word);
               fail_count++;
            end
            if (seen.parity_good !== want.parity_good) begin
               $error("parity_good: expected %0b, got %0b", want.parity_good, seen.parity_good);
               fail_count++;
            end
         end
      end
   end

   task automatic offer_event(input logic [1:0] kind, input logic [mfr_pkg::TIME_W-1:0] t);
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_edge_time <= t;
      do @(posedge clock); while (req_ready !== 1'b1);
      decode_event(kind, t);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic edge_after(input int delta);
      line_time = line_time + 16'(delta);
      offer_event(mfr_pkg::KIND_EDGE, line_time);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (status_due.size() != 0);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         mfr_pkg::CSR_HALF_BIT_MIN: win_cfg.half_bit_min = data;
         mfr_pkg::CSR_HALF_BIT_MAX: win_cfg.half_bit_max = data;
         mfr_pkg::CSR_FULL_BIT_MIN: win_cfg.full_bit_min = data;
         mfr_pkg::CSR_FULL_BIT_MAX: win_cfg.full_bit_max = data;
         mfr_pkg::CSR_IDLE_TIMEOUT: win_cfg.idle_timeout = data[mfr_pkg::IDLE_W-1:0];
         default: begin
         end
      endcase
   endtask

   task automatic program_windows(input logic [15:0] hmin, input logic [15:0] hmax,
                                  input logic [15:0] fmin, input logic [15:0] fmax,
                                  input logic [15:0] timeout);
      write_reg(mfr_pkg::CSR_HALF_BIT_MIN, hmin);
      write_reg(mfr_pkg::CSR_HALF_BIT_MAX, hmax);
      write_reg(mfr_pkg::CSR_FULL_BIT_MIN, fmin);
      write_reg(mfr_pkg::CSR_FULL_BIT_MAX, fmax);
      write_reg(mfr_pkg::CSR_IDLE_TIMEOUT, timeout);
      csr_valid <= 1'b0;
   endtask

   task automatic line_step(input int nominal, input int jitter, input int tick_pct,
                            input int corrupt_permille);
      int gap;
      if ($urandom_range(99) < tick_pct)
         repeat ($urandom_range(1, 2)) offer_event(mfr_pkg::KIND_TICK, 16'($urandom));
      gap = nominal + int'($urandom_range(2 * jitter)) - jitter;
      if ($urandom_range(999) < corrupt_permille)
         gap = $urandom;
      edge_after(gap);
   endtask

   task automatic send_frame(input int half_us, input int jitter_us, input int tick_pct,
                             input int corrupt_permille);
      logic last_bit;
      logic next_bit;
      int   cut_at;
      int   i;
      offer_event(mfr_pkg::KIND_RELEASE, 16'($urandom));
      edge_after($urandom);
      cut_at = -1;
      if ($urandom_range(5) == 0 && win_cfg.idle_timeout < 40)
         cut_at = $urandom_range(32);
      line_step(half_us, jitter_us, tick_pct, corrupt_permille);
      last_bit = 1'b1;
      for (i = 0; i < 33; i++) begin
         // drop the frame by running past the idle timeout
         if (i == cut_at)
            repeat (int'(win_cfg.idle_timeout) + 1)
               offer_event(mfr_pkg::KIND_TICK, 16'($urandom));
         next_bit = $urandom_range(1);
         if (next_bit == last_bit) begin
            line_step(half_us, jitter_us, tick_pct, corrupt_permille);
            line_step(half_us, jitter_us, tick_pct, corrupt_permille);
         end else begin
            line_step(2 * half_us, jitter_us, tick_pct, corrupt_permille);
         end
         last_bit = next_bit;
      end
      if ($urandom_range(1)) begin
         line_step(half_us, jitter_us, 0, 0);
         offer_event(mfr_pkg::KIND_TICK, 16'($urandom));
         line_step(2 * half_us, jitter_us, 0, 0);
      end
   endtask

   task automatic test_directed();
      offer_event(KIND_UNUSED, 16'hFFFF);
      offer_event(mfr_pkg::KIND_TICK, 16'h0000);
      line_time = 16'hFFFF;
      offer_event(mfr_pkg::KIND_EDGE, line_time);
      edge_after(500);
      edge_after(1000);
      edge_after(500);
      edge_after(500);
      edge_after(1000);
      edge_after(250);
      edge_after(1000);
      edge_after(7);
      edge_after(750);
      edge_after(1250);
      edge_after(260);
      edge_after(260);
      edge_after(0);
      edge_after(1251);
      edge_after(3);
      edge_after(249);
      edge_after(0);
      offer_event(mfr_pkg::KIND_RELEASE, 16'h0000);
      offer_event(mfr_pkg::KIND_TICK, 16'hFFFF);
   endtask

   task automatic test_default_frames();
      repeat (6) send_frame(500, 100, 10, 5);
   endtask

   task automatic test_receiver_stall();
      settle();
      // hold the result side while frames keep coming
      stall_request = 400;
      repeat (2) send_frame(500, 100, 10, 0);
   endtask

   task automatic test_fast_timing();
      settle();
      program_windows(16'd25, 16'd75, 16'd76, 16'd125, 16'd3);
      repeat (8) send_frame(50, 10, 5, 5);
   endtask

   task automatic test_wide_timing();
      settle();
      program_windows(16'd0, 16'd20000, 16'd20000, 16'hFFFF, 16'hA5FF);
      repeat (3) send_frame(12000, 500, 20, 5);
   endtask

   task automatic test_idle_saturation();
      edge_after($urandom);
      repeat (261) offer_event(mfr_pkg::KIND_TICK, 16'($urandom));
      offer_event(mfr_pkg::KIND_RELEASE, 16'($urandom));
   endtask

   task automatic test_noise();
      settle();
      write_reg(CSR_UNMAPPED, 16'($urandom));
      program_windows(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'h5A00);
      repeat (100) begin
         if ($urandom_range(3) == 0)
            offer_event(2'($urandom_range(3)), 16'($urandom));
         else if ($urandom_range(3) == 0)
            edge_after($urandom);
         else
            edge_after($urandom_range(40));
      end
   endtask

   initial begin
      win_cfg = {16'd250, 16'd750, 16'd750, 16'd1250, 8'd20};
      decoder = '0;
      src_idle_pct = 14;
      sink_idle_pct = 74;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_default_frames();
      test_receiver_stall();

      src_idle_pct = 74;
      sink_idle_pct = 14;
      test_fast_timing();

      src_idle_pct = 0;
      sink_idle_pct = 0;
      test_wide_timing();
      test_idle_saturation();
      test_noise();

      settle();
      repeat (5) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
